// ===== hdl/stli_pkg.sv =====
// shared types and constants of the interpolation lookup table
package stli_pkg;
   localparam int VW = 32;
   localparam int IW = 10;
   localparam int TABLE_DEPTH = 1024;
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;
   localparam logic [1:0] ST_INTERP = 2'd0;
   localparam logic [1:0] ST_MATCH  = 2'd1;
   localparam logic [1:0] ST_ABOVE  = 2'd2;
   localparam logic [1:0] ST_BELOW  = 2'd3;
   localparam logic [1:0] REG_COUNT = 2'd0;
   localparam logic [1:0] REG_TOL   = 2'd1;

   typedef struct packed {
      logic          action;
      logic [IW-1:0] entry_index;
      logic [VW-1:0] point_x;
      logic [VW-1:0] point_y;
      logic [VW-1:0] query_key;
   } req_type;

   typedef struct packed {
      logic [VW-1:0] value;
      logic [1:0]    status;
   } rsp_type;
endpackage

// ===== hdl/stli_front.sv =====
// input stage: two-entry queue of accepted beats
module stli_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stli_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_take,
   output stli_pkg::req_type q_data
);
   import stli_pkg::*;
   req_type   mem_ff [2];
   logic      wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push;
   assign req_stall = cnt_ff[1];
   assign push = req_valid && !req_stall;
   assign q_valid = cnt_ff != 2'd0;
   assign q_data = mem_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= req_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (q_take) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_take);
      end
   end
endmodule

// ===== hdl/stli_back.sv =====
// search and interpolation engine with table memories
module stli_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_take,
   input  stli_pkg::req_type q_data,
   input  logic [10:0]       point_count,
   input  logic [7:0]        match_tolerance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stli_pkg::rsp_type rsp_data
);
   import stli_pkg::*;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int MW = 2*VW + 2;
   typedef enum logic [3:0] {S_IDLE, S_LAST, S_LASTW, S_PROBE, S_PROBEW, S_DECIDE,
      S_RD1, S_RD2, S_RD2W, S_MUL, S_DIV, S_SAT, S_FIN, S_OUT} st_type;

   logic [VW-1:0] xmem [TABLE_DEPTH];
   logic [VW-1:0] ymem [TABLE_DEPTH];
   logic [AW-1:0] raddr;
   logic [VW-1:0] xr_ff, yr_ff;

   st_type st_ff;
   logic signed [VW-1:0] key_ff, x1_ff, y1_ff;
   logic signed [12:0] lo_ff, hi_ff, mid_ff, n_ff;
   logic [MW-1:0] rem_ff, num_ff, q_ff;
   logic [VW:0] dx_ff;
   logic neg_ff;
   logic [6:0] bit_ff;
   logic [1:0] status_ff;
   logic [VW-1:0] value_ff;
   logic [AW-1:0] addr_ff;

   logic ld;
   assign ld = q_valid && st_ff == S_IDLE && q_data.action == ACT_LOAD;
   assign raddr = addr_ff;
   always_ff @(posedge clock) begin
      if (ld) begin
         xmem[AW'(q_data.entry_index)] <= q_data.point_x;
         ymem[AW'(q_data.entry_index)] <= q_data.point_y;
      end
      xr_ff <= xmem[raddr];
      yr_ff <= ymem[raddr];
   end

   logic signed [12:0] nc, midc;
   logic signed [VW:0] diff;
   logic signed [VW:0] dyc, dkc, dxc;
   logic [VW:0] mdy, mdk;
   logic [MW:0] trial;
   logic signed [VW+2:0] res;
   logic [VW+1:0] qs;
   always_comb begin
      nc = 13'(point_count);
      if (nc < 13'sd2) nc = 13'sd2;
      if (nc > 13'(TABLE_DEPTH)) nc = 13'(TABLE_DEPTH);
      midc = (lo_ff + hi_ff) >>> 1;
      diff = {key_ff[VW-1], key_ff} - {xr_ff[VW-1], xr_ff};
      dyc = {yr_ff[VW-1], yr_ff} - {y1_ff[VW-1], y1_ff};
      dkc = {key_ff[VW-1], key_ff} - {x1_ff[VW-1], x1_ff};
      dxc = {xr_ff[VW-1], xr_ff} - {x1_ff[VW-1], x1_ff};
      mdy = dyc[VW] ? -dyc : dyc;
      mdk = dkc[VW] ? -dkc : dkc;
      trial = {rem_ff, num_ff[MW-1]} - {{(MW-VW){1'b0}}, dx_ff};
      qs = (q_ff > MW'(64'd1 << (VW+1))) ? (VW+2)'(64'd1 << (VW+1)) : q_ff[VW+1:0];
      res = neg_ff ? {{3{y1_ff[VW-1]}}, y1_ff} - {1'b0, qs}
                   : {{3{y1_ff[VW-1]}}, y1_ff} + {1'b0, qs};
   end

   assign q_take = q_valid && st_ff == S_IDLE;
   assign rsp_valid = st_ff == S_OUT;
   assign rsp_data.value = value_ff;
   assign rsp_data.status = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         case (st_ff)
            S_IDLE: if (q_valid && q_data.action == ACT_QUERY) begin
               key_ff <= q_data.query_key; n_ff <= nc;
               addr_ff <= AW'(nc - 13'sd1); st_ff <= S_LAST;
            end
            S_LAST: st_ff <= S_LASTW;
            S_LASTW: begin
               if (diff > 0) begin
                  value_ff <= yr_ff; status_ff <= ST_ABOVE; st_ff <= S_OUT;
               end else begin
                  lo_ff <= 13'sd0; hi_ff <= n_ff - 13'sd1; st_ff <= S_PROBE;
               end
            end
            S_PROBE: begin
               if (lo_ff <= hi_ff) begin
                  mid_ff <= midc; addr_ff <= AW'(midc); st_ff <= S_PROBEW;
               end else st_ff <= S_DECIDE;
            end
            S_PROBEW: st_ff <= S_FIN;
            S_FIN: begin
               if (diff < 0) begin
                  hi_ff <= mid_ff - 13'sd1; st_ff <= S_PROBE;
               end else if (diff <= $signed({1'b0, 24'd0, match_tolerance})) begin
                  value_ff <= yr_ff; status_ff <= ST_MATCH; st_ff <= S_OUT;
               end else begin
                  lo_ff <= mid_ff + 13'sd1; st_ff <= S_PROBE;
               end
            end
            S_DECIDE: begin
               if (hi_ff < 0) begin
                  addr_ff <= '0; status_ff <= ST_BELOW; st_ff <= S_RD2;
               end else if (lo_ff >= n_ff) begin
                  addr_ff <= AW'(n_ff - 13'sd1); status_ff <= ST_ABOVE; st_ff <= S_RD2;
               end else begin
                  addr_ff <= AW'(hi_ff); status_ff <= ST_INTERP; st_ff <= S_RD1;
               end
            end
            S_RD1: st_ff <= S_RD2;
            S_RD2: begin
               if (status_ff == ST_INTERP && addr_ff == AW'(hi_ff)) begin
                  x1_ff <= xr_ff; y1_ff <= yr_ff; addr_ff <= AW'(lo_ff); st_ff <= S_RD1;
               end else st_ff <= S_RD2W;
            end
            S_RD2W: begin
               if (status_ff != ST_INTERP) begin
                  value_ff <= yr_ff; st_ff <= S_OUT;
               end else if (dxc <= 0) begin
                  value_ff <= y1_ff; st_ff <= S_OUT;
               end else begin
                  dx_ff <= dxc; neg_ff <= dyc[VW] != dkc[VW];
                  num_ff <= MW'(mdy) * MW'(mdk); st_ff <= S_MUL;
               end
            end
            S_MUL: begin
               rem_ff <= '0; q_ff <= '0; bit_ff <= 7'(MW); st_ff <= S_DIV;
            end
            S_DIV: begin
               num_ff <= num_ff << 1;
               if (!trial[MW]) begin
                  rem_ff <= trial[MW-1:0]; q_ff <= {q_ff[MW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[MW-2:0], num_ff[MW-1]}; q_ff <= {q_ff[MW-2:0], 1'b0};
               end
               bit_ff <= bit_ff - 7'd1;
               if (bit_ff == 7'd1) st_ff <= S_SAT;
            end
            S_SAT: begin
               if (res > $signed({4'b0000, {(VW-1){1'b1}}})) begin
                  value_ff <= {1'b0, {(VW-1){1'b1}}};
               end else if (res < $signed({4'b1111, {(VW-1){1'b0}}})) begin
                  value_ff <= {1'b1, {(VW-1){1'b0}}};
               end else value_ff <= res[VW-1:0];
               st_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hdl/sorted_table_linear_interpolator_top.sv =====
// top level of the interpolation lookup table
// Loads (action 0) write one point per beat and give no result; each query gives
// one result beat. Beats enter a two-entry queue in front of the search engine,
// which works on one query at a time and writes a load straight from its idle
// state. A query reads the last point, then runs a binary search (up to 11 probes
// for 1024 points); a match or a clamp ends it early. Interpolation adds two point
// reads, a multiply, a serial restoring division of the 66-bit product and a
// saturation step; the result is then held until it is taken.
module sorted_table_linear_interpolator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stli_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stli_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import stli_pkg::*;
   logic [10:0] cnt_ff;
   logic [7:0]  tol_ff;
   logic q_valid, q_take;
   req_type q_data;
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 11'd2; tol_ff <= 8'd0;
      end else if (psel && penable && pwrite) begin
         if (paddr[2:2] == REG_COUNT[0:0] && paddr[1:0] == 2'd0) cnt_ff <= pwdata[10:0];
         if (paddr[2:2] == REG_TOL[0:0] && paddr[1:0] == 2'd0) tol_ff <= pwdata[7:0];
      end
   end
   always_comb begin
      case (paddr)
         3'd0: prdata = {21'd0, cnt_ff};
         3'd4: prdata = {24'd0, tol_ff};
         default: prdata = 32'd0;
      endcase
   end
   stli_front u_front (.clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data);
   stli_back u_back (
      .clock, .reset, .q_valid, .q_take, .q_data, .point_count(cnt_ff),
      .match_tolerance(tol_ff), .rsp_valid, .rsp_stall, .rsp_data);
endmodule

// ===== hdl/stli_checker.sv =====
// port-level checks of the interpolation lookup table
module stli_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input stli_pkg::rsp_type rsp_data,
   input logic pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp held");
   a_rdy: assert property (@(posedge clock) pready) else $error("pready low");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("reset state");
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_stall, rsp_valid})) else $error("handshake unknown");
endmodule
bind sorted_table_linear_interpolator_top stli_checker u_chk (.clock, .reset, .req_valid,
   .req_stall, .rsp_valid, .rsp_stall, .rsp_data, .pready);
